// ===== hw/rtl/bsit_pkg.sv =====
// Shared types and constants for the binned sorted insert table.
// Holds result codes, opcodes, the controller state type and the
// command and status structs that join the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package bsit_pkg;

    // Fixed field widths of one transaction.
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int TAG_W   = 16;
    localparam int KEY_W   = DAY_W + HOUR_W;
    localparam int ENTRY_W = KEY_W + TAG_W;

    typedef logic [2:0] t_code;

    // Result status codes.
    localparam t_code ST_INSERTED  = 3'd0;
    localparam t_code ST_DUPLICATE = 3'd1;
    localparam t_code ST_FULL      = 3'd2;
    localparam t_code ST_LISTED    = 3'd3;
    localparam t_code ST_EMPTY     = 3'd4;

    // Opcodes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LIST   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_PLACE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_RESP,
        S_LIST_RD,
        S_LIST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  ready;       // input channel may take a transaction
        logic  load;        // latch the accepted transaction
        logic  inc_idx;     // advance the scan or list index
        logic  rd_idx;      // read the slot at the index
        logic  rd_prev;     // read the slot just below the shift pointer
        logic  wr_shift;    // write read data one slot up
        logic  dec_ptr;     // step the shift pointer down
        logic  wr_new;      // store the new entry and bump the bin count
        logic  set_code;    // latch a result code
        t_code code;
        logic  push_code;   // send the latched code as a single result
        logic  push_entry;  // send the read entry as a listed result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_list;
        logic month_ok;
        logic cnt_zero;
        logic scan_end;
        logic key_ge;
        logic key_eq;
        logic full;
        logic shift_end;
        logic list_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/bsit_ctrl.sv =====
// Controller state machine of the binned sorted insert table.
// Depends on bsit_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module bsit_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  bsit_pkg::t_sts     i_sts,
    output bsit_pkg::t_cmd     o_cmd
);
    import bsit_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (!i_sts.is_list) begin
                    n_state = i_sts.month_ok ? S_SCAN_RD : S_RESP;
                end else begin
                    n_state = (!i_sts.month_ok || i_sts.cnt_zero) ? S_RESP : S_LIST_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = i_sts.scan_end ? S_PLACE : S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.key_ge) begin
                    n_state = i_sts.key_eq ? S_RESP : S_PLACE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_PLACE: begin
                n_state = i_sts.full ? S_RESP : S_SHIFT_RD;
            end
            S_SHIFT_RD: begin
                n_state = i_sts.shift_end ? S_WRITE : S_SHIFT_WR;
            end
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_WRITE:    n_state = S_RESP;
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_LIST_RD:  n_state = S_LIST_OUT;
            S_LIST_OUT: begin
                if (i_sts.out_free) n_state = i_sts.list_last ? S_IDLE : S_LIST_RD;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        o_cmd.code = ST_INSERTED;
        case (r_state)
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                o_cmd.load  = i_valid;
            end
            S_DISPATCH: begin
                o_cmd.set_code = 1'b1;
                o_cmd.code     = i_sts.is_list ? ST_EMPTY : ST_FULL;
            end
            S_SCAN_RD: begin
                o_cmd.rd_idx = !i_sts.scan_end;
            end
            S_SCAN_CMP: begin
                o_cmd.inc_idx  = !i_sts.key_ge;
                o_cmd.set_code = i_sts.key_ge && i_sts.key_eq;
                o_cmd.code     = ST_DUPLICATE;
            end
            S_PLACE: begin
                // Full code was latched at dispatch; nothing to do here.
                o_cmd.code = ST_FULL;
            end
            S_SHIFT_RD: begin
                o_cmd.rd_prev = !i_sts.shift_end;
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.dec_ptr  = 1'b1;
            end
            S_WRITE: begin
                o_cmd.wr_new   = 1'b1;
                o_cmd.set_code = 1'b1;
                o_cmd.code     = ST_INSERTED;
            end
            S_RESP: begin
                o_cmd.push_code = i_sts.out_free;
            end
            S_LIST_RD: begin
                o_cmd.rd_idx = 1'b1;
            end
            S_LIST_OUT: begin
                o_cmd.push_entry = i_sts.out_free;
                o_cmd.inc_idx    = i_sts.out_free;
                o_cmd.code       = ST_LISTED;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsit_datapath.sv =====
// Datapath of the binned sorted insert table: entry memory, bin counts,
// scan and shift pointers, key compare and the output register.
// Depends on bsit_pkg for field widths, result codes and the command structs.
`timescale 1ns / 1ps
`default_nettype none

module bsit_datapath #(
    parameter int SLOTS_PER_BIN = 16,
    parameter int BIN_COUNT     = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  bsit_pkg::t_cmd                     i_cmd,
    output bsit_pkg::t_sts                     o_sts,
    input  wire logic                          i_opcode,
    input  wire logic [bsit_pkg::MONTH_W-1:0]  i_month,
    input  wire logic [bsit_pkg::DAY_W-1:0]    i_day,
    input  wire logic [bsit_pkg::HOUR_W-1:0]   i_hour,
    input  wire logic [bsit_pkg::TAG_W-1:0]    i_event_tag,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic [2:0]                         o_status,
    output logic [bsit_pkg::DAY_W-1:0]         o_out_day,
    output logic [bsit_pkg::HOUR_W-1:0]        o_out_hour,
    output logic [bsit_pkg::TAG_W-1:0]         o_out_tag,
    output logic                               o_last
);
    import bsit_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS_PER_BIN);
    localparam int CNT_W  = $clog2(SLOTS_PER_BIN + 1);
    localparam int BIN_W  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int DEPTH  = BIN_COUNT * SLOTS_PER_BIN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [MONTH_W:0]  BINS_M = (MONTH_W + 1)'(BIN_COUNT);
    localparam logic [CNT_W-1:0]  SLOTS_C = CNT_W'(SLOTS_PER_BIN);

    // Latched transaction.
    logic                r_op;
    logic                r_month_ok;
    logic [BIN_W-1:0]    r_bin;
    logic [DAY_W-1:0]    r_day;
    logic [HOUR_W-1:0]   r_hour;
    logic [TAG_W-1:0]    r_tag;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_ptr;
    logic [2:0]          r_code;

    // Bin fill counts and entry memory.
    logic [CNT_W-1:0]    r_counts [BIN_COUNT];
    logic [ENTRY_W-1:0]  r_mem [DEPTH];
    logic [ENTRY_W-1:0]  r_rd_data;

    // Output register.
    logic                r_out_valid;
    logic [2:0]          r_out_status;
    logic [DAY_W-1:0]    r_out_day;
    logic [HOUR_W-1:0]   r_out_hour;
    logic [TAG_W-1:0]    r_out_tag;
    logic                r_out_last;

    logic                month_ok;
    logic [BIN_W-1:0]    n_bin;
    logic [CNT_W-1:0]    ptr_dec;
    logic [CNT_W-1:0]    idx_inc;
    logic [KEY_W-1:0]    new_key;
    logic [KEY_W-1:0]    rd_key;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                mem_rd;
    logic                mem_wr;
    logic                out_free;

    // Month decode: an out-of-range month maps to bin zero and is flagged.
    assign month_ok = (i_month != '0) && ({1'b0, i_month} <= BINS_M);
    assign n_bin    = month_ok ? BIN_W'(i_month - MONTH_W'(1)) : '0;

    assign ptr_dec  = r_ptr - CNT_W'(1);
    assign idx_inc  = r_idx + CNT_W'(1);
    assign new_key  = {r_day, r_hour};
    assign rd_key   = r_rd_data[ENTRY_W-1:TAG_W];
    assign out_free = !r_out_valid || !i_stall;

    // Memory address and data selection.
    always_comb begin
        rd_addr = ADDR_W'(r_bin * SLOTS_PER_BIN) +
                  ADDR_W'(i_cmd.rd_prev ? ptr_dec[SLOT_W-1:0] : r_idx[SLOT_W-1:0]);
        wr_addr = ADDR_W'(r_bin * SLOTS_PER_BIN) +
                  ADDR_W'(i_cmd.wr_new ? r_idx[SLOT_W-1:0] : r_ptr[SLOT_W-1:0]);
        wr_data = i_cmd.wr_new ? {r_day, r_hour, r_tag} : r_rd_data;
        mem_rd  = i_cmd.rd_idx || i_cmd.rd_prev;
        mem_wr  = i_cmd.wr_new || i_cmd.wr_shift;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (mem_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Transaction latch and pointers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_opcode;
            r_month_ok <= month_ok;
            r_bin      <= n_bin;
            r_day      <= i_day;
            r_hour     <= i_hour;
            r_tag      <= i_event_tag;
            r_cnt      <= r_counts[n_bin];
            r_ptr      <= r_counts[n_bin];
        end else if (i_cmd.dec_ptr) begin
            r_ptr <= ptr_dec;
        end
        if (i_cmd.set_code) begin
            r_code <= i_cmd.code;
        end
    end

    // Scan and list index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx <= idx_inc;
        end
    end

    // Bin fill counts, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BIN_COUNT; b++) begin
                r_counts[b] <= '0;
            end
        end else if (i_cmd.wr_new) begin
            r_counts[r_bin] <= r_cnt + CNT_W'(1);
        end
    end

    // Output register: loads only when empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_code || i_cmd.push_entry) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_code) begin
            r_out_status <= r_code;
            r_out_day    <= '0;
            r_out_hour   <= '0;
            r_out_tag    <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.push_entry) begin
            r_out_status <= ST_LISTED;
            r_out_day    <= r_rd_data[ENTRY_W-1 -: DAY_W];
            r_out_hour   <= r_rd_data[TAG_W +: HOUR_W];
            r_out_tag    <= r_rd_data[TAG_W-1:0];
            r_out_last   <= (idx_inc == r_cnt);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_out_day  = r_out_day;
    assign o_out_hour = r_out_hour;
    assign o_out_tag  = r_out_tag;
    assign o_last     = r_out_last;

    // Status toward the controller.
    always_comb begin
        o_sts.is_list   = (r_op == OP_LIST);
        o_sts.month_ok  = r_month_ok;
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.scan_end  = (r_idx == r_cnt);
        o_sts.key_ge    = (rd_key >= new_key);
        o_sts.key_eq    = (rd_key == new_key);
        o_sts.full      = (r_cnt >= SLOTS_C);
        o_sts.shift_end = (r_ptr == r_idx);
        o_sts.list_last = (idx_inc == r_cnt);
        o_sts.out_free  = out_free;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/binned_sorted_insert_table.sv =====
// Binned sorted insert table: ordered per-month entry lists in one memory.
// Insert: scans the bin in key order, one read and compare per entry, until a key not below
// the new one; a duplicate key or a full bin is rejected, else entries shift up (read, write).
// List: reads and sends each entry of the bin; an empty list or a reject sends a single result code.
// One transaction at a time; a stalled result holds back the next result, but a waiting result does not block input.
// Synchronous active-low reset clears all bin counts; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module binned_sorted_insert_table #(
    parameter int SLOTS_PER_BIN = 16,
    parameter int BIN_COUNT     = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_opcode,
    input  wire logic [bsit_pkg::MONTH_W-1:0]  i_month,
    input  wire logic [bsit_pkg::DAY_W-1:0]    i_day,
    input  wire logic [bsit_pkg::HOUR_W-1:0]   i_hour,
    input  wire logic [bsit_pkg::TAG_W-1:0]    i_event_tag,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [2:0]                         o_status,
    output logic [bsit_pkg::DAY_W-1:0]         o_out_day,
    output logic [bsit_pkg::HOUR_W-1:0]        o_out_hour,
    output logic [bsit_pkg::TAG_W-1:0]         o_out_tag,
    output logic                               o_last
);
    import bsit_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Input channel stalls whenever the controller is busy.
    assign o_stall = !w_cmd.ready;

    bsit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    bsit_datapath #(
        .SLOTS_PER_BIN (SLOTS_PER_BIN),
        .BIN_COUNT     (BIN_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_opcode    (i_opcode),
        .i_month     (i_month),
        .i_day       (i_day),
        .i_hour      (i_hour),
        .i_event_tag (i_event_tag),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_out_day   (o_out_day),
        .o_out_hour  (o_out_hour),
        .o_out_tag   (o_out_tag),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bsit_checker.sv =====
// Port-level checker for the binned sorted insert table, bound to the top level.
// Depends on bsit_pkg for the result codes.
`timescale 1ns / 1ps
`default_nettype none

module bsit_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          o_stall,
    input  wire logic                          o_valid,
    input  wire logic                          i_stall,
    input  wire logic [2:0]                    o_status,
    input  wire logic [bsit_pkg::DAY_W-1:0]    o_out_day,
    input  wire logic [bsit_pkg::HOUR_W-1:0]   o_out_hour,
    input  wire logic [bsit_pkg::TAG_W-1:0]    o_out_tag,
    input  wire logic                          o_last
);
    import bsit_pkg::*;

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_out_day)
            && $stable(o_out_hour) && $stable(o_out_tag) && $stable(o_last))
        else $error("stalled result changed");

    // Every result other than a listed entry is final and carries no entry.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_LISTED) |->
            o_last && (o_out_day == '0) && (o_out_hour == '0) && (o_out_tag == '0))
        else $error("non-list result with payload or without last");

    // An accepted transaction keeps the input side stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted while previous transaction still in work");

    // Reset leaves no result pending and the input side open.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("state after reset wrong");

endmodule

bind binned_sorted_insert_table bsit_checker u_bsit_checker (.*);

`default_nettype wire
